>>> rtl/tst_pkg.sv
package tst_pkg;

  localparam int SLOTS      = 2;
  localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W       = 7;
  localparam int KEY_W      = 8;
  localparam int POS_W      = 16;
  localparam int SEL_W      = 4;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_MOVE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [SEL_W-1:0] slot_index;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  new_id;
    logic             start_failed;
    logic             hit;
    logic             rep_active;
    logic [ID_W-1:0]  rep_id;
    logic [POS_W-1:0] rep_x;
    logic [POS_W-1:0] rep_y;
  } res_t;

endpackage

>>> rtl/touch_slot_table_top.sv
// Beats pass the front register and the queue into the result register.
// Throughput: one beat per cycle; front register, 2-entry queue and
//   result register each stall on their own.
// Reset (rst_ni low, async): all slots free, ids, coordinates and the id
//   counter zeroed, every queue emptied; no clearing pass.
module touch_slot_table_top import tst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       op_i,
  input  logic [KEY_W-1:0] touch_id_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [SEL_W-1:0] slot_index_i,
  output logic             empty,
  input  logic             pop,
  output logic [ID_W-1:0]  new_id_o,
  output logic             start_failed_o,
  output logic             hit_o,
  output logic             rep_active_o,
  output logic [ID_W-1:0]  rep_id_o,
  output logic [POS_W-1:0] rep_x_o,
  output logic [POS_W-1:0] rep_y_o
);

  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;
  res_t res;

  tst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .op_i         (op_i),
    .touch_id_i   (touch_id_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .slot_index_i (slot_index_i),
    .cmd_o        (f_cmd),
    .cmd_valid_o  (f_valid),
    .cmd_ready_i  (f_ready)
  );

  tst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (f_cmd),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .out_o       (q_cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready)
  );

  tst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign new_id_o       = res.new_id;
  assign start_failed_o = res.start_failed;
  assign hit_o          = res.hit;
  assign rep_active_o   = res.rep_active;
  assign rep_id_o       = res.rep_id;
  assign rep_x_o        = res.rep_x;
  assign rep_y_o        = res.rep_y;

endmodule

>>> rtl/tst_front.sv
module tst_front import tst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [1:0]       op_i,
  input  logic [KEY_W-1:0] touch_id_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [SEL_W-1:0] slot_index_i,
  output cmd_t             cmd_o,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i
);

  logic valid_q;
  cmd_t cmd_q, cmd_d;
  logic accept;

  assign full_o = valid_q & ~cmd_ready_i;
  assign accept = push_i & ~full_o;

  // move compares on the low 7 bits only; stop keeps all 8
  always_comb begin
    cmd_d.op         = op_e'(op_i);
    cmd_d.key        = touch_id_i;
    cmd_d.pos_x      = pos_x_i;
    cmd_d.pos_y      = pos_y_i;
    cmd_d.slot_index = slot_index_i;
    unique case (op_e'(op_i))
      OP_MOVE: cmd_d.key = {1'b0, touch_id_i[ID_W-1:0]};
      default: cmd_d.key = touch_id_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = valid_q;

endmodule

>>> rtl/tst_queue.sv
module tst_queue import tst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t in_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  output cmd_t out_o,
  output logic out_valid_o,
  input  logic out_ready_i
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              wr, rd;

  assign in_ready_o  = (cnt_q != QCNT_W'(QDEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign wr          = in_valid_i & in_ready_o;
  assign rd          = out_valid_o & out_ready_i;
  assign out_o       = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (rd) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= in_i;
    end
  end

endmodule

>>> rtl/tst_back.sv
module tst_back import tst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  output res_t res_o,
  output logic empty_o,
  input  logic pop_i
);

  logic [SLOTS-1:0] used_q, used_d;
  logic [ID_W-1:0]  ident_q [SLOTS];
  logic [ID_W-1:0]  ident_d [SLOTS];
  logic [POS_W-1:0] x_q [SLOTS];
  logic [POS_W-1:0] x_d [SLOTS];
  logic [POS_W-1:0] y_q [SLOTS];
  logic [POS_W-1:0] y_d [SLOTS];
  logic [ID_W-1:0]  next_q, next_d;
  logic             res_valid_q;
  res_t             res_q, res_d;
  logic             take;
  logic             found;
  logic [SLOT_IDX_W-1:0] idx, sel;
  logic             sel_ok;

  assign cmd_ready_o = ~res_valid_q | pop_i;
  assign take        = cmd_valid_i & cmd_ready_o;
  assign sel_ok      = ({1'b0, cmd_i.slot_index} < (SEL_W + 1)'(SLOTS));
  assign sel         = SLOT_IDX_W'(cmd_i.slot_index);

  always_comb begin
    used_d  = used_q;
    ident_d = ident_q;
    x_d     = x_q;
    y_d     = y_q;
    next_d  = next_q;
    found   = 1'b0;
    idx     = '0;
    res_d   = '0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        used_d = '0;
        next_d = '0;
        for (int i = 0; i < SLOTS; i++) begin
          ident_d[i] = '0;
          x_d[i]     = '0;
          y_d[i]     = '0;
        end
      end
      OP_START: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && !used_q[i]) begin
            found = 1'b1;
            idx   = SLOT_IDX_W'(i);
          end
        end
        if (found) begin
          used_d[idx]  = 1'b1;
          ident_d[idx] = next_q;
          x_d[idx]     = cmd_i.pos_x;
          y_d[idx]     = cmd_i.pos_y;
          next_d       = next_q + 1'b1;
          res_d.new_id = next_q;
        end else begin
          res_d.start_failed = 1'b1;
        end
      end
      OP_STOP, OP_MOVE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && used_q[i] && ({1'b0, ident_q[i]} == cmd_i.key)) begin
            found = 1'b1;
            idx   = SLOT_IDX_W'(i);
          end
        end
        res_d.hit = found;
        if (found) begin
          if (cmd_i.op == OP_STOP) begin
            used_d[idx] = 1'b0;
          end else begin
            x_d[idx] = cmd_i.pos_x;
            y_d[idx] = cmd_i.pos_y;
          end
        end
      end
      default: ;
    endcase
    if (sel_ok) begin
      res_d.rep_active = used_d[sel];
      res_d.rep_id     = used_d[sel] ? ident_d[sel] : '0;
      res_d.rep_x      = x_d[sel];
      res_d.rep_y      = y_d[sel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      next_q      <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        ident_q[i] <= '0;
        x_q[i]     <= '0;
        y_q[i]     <= '0;
      end
    end else begin
      if (take) begin
        used_q      <= used_d;
        ident_q     <= ident_d;
        x_q         <= x_d;
        y_q         <= y_d;
        next_q      <= next_d;
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_o   = res_q;
  assign empty_o = ~res_valid_q;

endmodule

>>> rtl/tst_checker.sv
module tst_checker import tst_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input logic [ID_W-1:0]  new_id_o,
  input logic             start_failed_o,
  input logic             hit_o,
  input logic             rep_active_o,
  input logic [ID_W-1:0]  rep_id_o,
  input logic [POS_W-1:0] rep_x_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result pending during reset");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result beat dropped without pop");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(rep_x_o) && $stable(new_id_o))
    else $error("stalled result changed");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && start_failed_o |-> new_id_o == '0 && !hit_o)
    else $error("failed start carries id or hit");

  a_free_slot_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !rep_active_o |-> rep_id_o == '0)
    else $error("free slot reports an id");

endmodule

bind touch_slot_table_top tst_checker u_tst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .new_id_o       (new_id_o),
  .start_failed_o (start_failed_o),
  .hit_o          (hit_o),
  .rep_active_o   (rep_active_o),
  .rep_id_o       (rep_id_o),
  .rep_x_o        (rep_x_o)
);

>>> bench/touch_slot_table_top_test.sv
`timescale 1ns / 100ps

module touch_slot_table_top_test;
  import tst_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_RANDOM = 1600;

  class slot_table_model;
    bit               used[SLOTS];
    logic [ID_W-1:0]  ident[SLOTS];
    logic [POS_W-1:0] xs[SLOTS];
    logic [POS_W-1:0] ys[SLOTS];
    logic [ID_W-1:0]  next_id;
    res_t             want_q[$];
    int beats, starts_ok, starts_full, hits, misses, wraps, reports, mismatches;

    function new();
      wipe();
    endfunction

    function void wipe();
      for (int k = 0; k < SLOTS; k++) begin
        used[k] = 1'b0;
        ident[k] = '0;
        xs[k] = '0;
        ys[k] = '0;
      end
      next_id = '0;
    endfunction

    // expected report for one accepted command beat
    function void apply_touch_cmd(op_e op, logic [KEY_W-1:0] key, logic [POS_W-1:0] x,
                                  logic [POS_W-1:0] y, logic [SEL_W-1:0] sel);
      res_t r;
      int   slot;
      r = '0;
      slot = -1;
      beats++;
      case (op)
        OP_CLEAR: begin
          wipe();
        end
        OP_START: begin
          for (int k = SLOTS - 1; k >= 0; k--) if (!used[k]) slot = k;
          if (slot >= 0) begin
            used[slot] = 1'b1;
            ident[slot] = next_id;
            xs[slot] = x;
            ys[slot] = y;
            r.new_id = next_id;
            if (next_id == '1) wraps++;
            next_id = next_id + 1'b1;
            starts_ok++;
          end else begin
            r.start_failed = 1'b1;
            starts_full++;
          end
        end
        OP_STOP: begin
          // full 8-bit compare: keys above 127 never match
          for (int k = SLOTS - 1; k >= 0; k--)
            if (used[k] && {1'b0, ident[k]} == key) slot = k;
          if (slot >= 0) begin
            used[slot] = 1'b0;
            r.hit = 1'b1;
          end
        end
        default: begin
          for (int k = SLOTS - 1; k >= 0; k--)
            if (used[k] && ident[k] == key[ID_W-1:0]) slot = k;
          if (slot >= 0) begin
            xs[slot] = x;
            ys[slot] = y;
            r.hit = 1'b1;
          end
        end
      endcase
      if (op inside {OP_STOP, OP_MOVE}) begin
        if (r.hit) hits++;
        else misses++;
      end
      if (sel < SLOTS) begin
        r.rep_active = used[sel];
        r.rep_id = used[sel] ? ident[sel] : '0;
        r.rep_x = xs[sel];
        r.rep_y = ys[sel];
      end
      want_q.push_back(r);
    endfunction

    function void check_report(res_t got);
      res_t want;
      bit   bad;
      reports++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report beat %0d: %p", reports, got);
        return;
      end
      want = want_q.pop_front();
      bad = (got.new_id !== want.new_id) || (got.start_failed !== want.start_failed) ||
            (got.hit !== want.hit) || (got.rep_active !== want.rep_active) ||
            (got.rep_id !== want.rep_id) || (got.rep_x !== want.rep_x) ||
            (got.rep_y !== want.rep_y);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on report beat %0d", reports);
          $display("  exp id=%0d fail=%0b hit=%0b act=%0b rid=%0d x=%h y=%h", want.new_id,
                   want.start_failed, want.hit, want.rep_active, want.rep_id, want.rep_x,
                   want.rep_y);
          $display("  got id=%0d fail=%0b hit=%0b act=%0b rid=%0d x=%h y=%h", got.new_id,
                   got.start_failed, got.hit, got.rep_active, got.rep_id, got.rep_x,
                   got.rep_y);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  logic [1:0]       op_i;
  logic [KEY_W-1:0] touch_id_i;
  logic [POS_W-1:0] pos_x_i;
  logic [POS_W-1:0] pos_y_i;
  logic [SEL_W-1:0] slot_index_i;
  logic             empty;
  logic             pop;
  logic [ID_W-1:0]  new_id_o;
  logic             start_failed_o;
  logic             hit_o;
  logic             rep_active_o;
  logic [ID_W-1:0]  rep_id_o;
  logic [POS_W-1:0] rep_x_o;
  logic [POS_W-1:0] rep_y_o;

  slot_table_model sb = new();
  int cycles = 0;
  int sent = 0;

  touch_slot_table_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .touch_id_i     (touch_id_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .slot_index_i   (slot_index_i),
    .empty          (empty),
    .pop            (pop),
    .new_id_o       (new_id_o),
    .start_failed_o (start_failed_o),
    .hit_o          (hit_o),
    .rep_active_o   (rep_active_o),
    .rep_id_o       (rep_id_o),
    .rep_x_o        (rep_x_o),
    .rep_y_o        (rep_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, sb.want_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_wait();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic send_cmd(op_e op, logic [KEY_W-1:0] key, logic [POS_W-1:0] x,
                          logic [POS_W-1:0] y, logic [SEL_W-1:0] sel);
    int gap;
    gap = ((sent / 150) % 4 == 3) ? 0 : pick_wait();
    op_i <= op;
    touch_id_i <= key;
    pos_x_i <= x;
    pos_y_i <= y;
    slot_index_i <= sel;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.apply_touch_cmd(op, key, x, y, sel);
    sent++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // mostly commands aimed at live touches, some noise
  task automatic send_random(bit allow_clear);
    int               r;
    int               live[$];
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [SEL_W-1:0] sel;
    r = $urandom_range(999);
    for (int k = 0; k < SLOTS; k++) if (sb.used[k]) live.push_back(k);
    if (allow_clear && r < 20) op = OP_CLEAR;
    else if (r < 380) op = OP_START;
    else if (r < 690) op = OP_STOP;
    else op = OP_MOVE;
    key = KEY_W'($urandom);
    if (op inside {OP_STOP, OP_MOVE} && live.size() > 0 && $urandom_range(9) < 8) begin
      key = {1'b0, sb.ident[live[$urandom_range(live.size() - 1)]]};
      if (op == OP_MOVE && $urandom_range(3) == 0) key[KEY_W-1] = 1'b1;
    end
    sel = ($urandom_range(9) < 8) ? SEL_W'($urandom_range(SLOTS - 1)) : SEL_W'($urandom);
    send_cmd(op, key, pick_pos(), pick_pos(), sel);
  endtask

  initial begin
    res_t got;
    int   stall;
    rst_ni <= 1'b0;
    push <= 1'b0;
    pop <= 1'b0;
    op_i <= OP_CLEAR;
    touch_id_i <= '0;
    pos_x_i <= '0;
    pos_y_i <= '0;
    slot_index_i <= '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      stall = ((cycles / 500) % 4 == 1) ? 0 : pick_wait();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      if (!empty) begin
        got.new_id = new_id_o;
        got.start_failed = start_failed_o;
        got.hit = hit_o;
        got.rep_active = rep_active_o;
        got.rep_id = rep_id_o;
        got.rep_x = rep_x_o;
        got.rep_y = rep_y_o;
        sb.check_report(got);
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    send_cmd(OP_CLEAR, 8'h00, 16'h0000, 16'h0000, 4'd15);
    send_cmd(OP_START, 8'h00, 16'hffff, 16'h0000, 4'd0);
    send_cmd(OP_START, 8'h00, 16'h0000, 16'hffff, 4'd1);
    // table full
    send_cmd(OP_START, 8'h00, 16'h1111, 16'h2222, 4'd0);
    send_cmd(OP_MOVE, 8'h00, 16'h1234, 16'habcd, 4'd0);
    // move drops bit 7 of the id
    send_cmd(OP_MOVE, 8'h80, 16'hffff, 16'hffff, 4'd0);
    // stop compares all 8 bits
    send_cmd(OP_STOP, 8'h80, 16'h0000, 16'h0000, 4'd0);
    send_cmd(OP_STOP, 8'hff, 16'h0000, 16'h0000, 4'd3);
    // freed slot keeps its coordinates
    send_cmd(OP_STOP, 8'h01, 16'h0000, 16'h0000, 4'd1);
    send_cmd(OP_MOVE, 8'h01, 16'h7777, 16'h8888, 4'd1);
    send_cmd(OP_STOP, 8'h01, 16'h0000, 16'h0000, 4'd1);
    send_cmd(OP_START, 8'h00, 16'h5555, 16'haaaa, 4'd1);
    send_cmd(OP_STOP, 8'h00, 16'h0000, 16'h0000, 4'd0);
    send_cmd(OP_START, 8'h00, 16'haaaa, 16'h5555, 4'd0);
    send_cmd(OP_MOVE, 8'h7f, 16'hffff, 16'hffff, 4'd15);
    send_cmd(OP_STOP, 8'h7f, 16'h0000, 16'h0000, 4'd2);
    send_cmd(OP_CLEAR, 8'hff, 16'hffff, 16'hffff, 4'd1);
    send_cmd(OP_STOP, 8'h00, 16'h0000, 16'h0000, 4'd0);
    send_cmd(OP_START, 8'h00, 16'hffff, 16'hffff, 4'd0);
    send_cmd(OP_START, 8'h00, 16'h0001, 16'h8000, 4'd14);
    send_cmd(OP_CLEAR, 8'h00, 16'h0000, 16'h0000, 4'd0);
    // no clears in the first half so the id counter wraps
    for (int n = 0; n < N_RANDOM; n++) send_random(n >= N_RANDOM / 2);
    push <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d commands, %0d starts (%0d on a full table), %0d id wraps",
             sb.beats, sb.starts_ok + sb.starts_full, sb.starts_full, sb.wraps);
    $display("%0d stop/move hits, %0d misses, %0d reports checked",
             sb.hits, sb.misses, sb.reports);
    if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d reports missing", sb.mismatches, sb.want_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
